/* sv/stpr_pkg.sv */
// Shared constants, field widths and a helper function for the stepper ramp pulser.
// No dependencies; used by the channel interfaces and the top level.
package stpr_pkg;

    // Field widths of the two channels
    localparam int MODE_W  = 2;
    localparam int TIME_W  = 32;
    localparam int SPEED_W = 24;
    localparam int PINS_W  = 3;
    localparam int MSTEP_W = 3;

    // Register widths and map
    localparam int MAXSPD_W = 23;
    localparam int ACCEL_W  = 24;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;
    localparam logic [APB_AW-1:0] ADDR_MAX_SPEED   = 4'h0;
    localparam logic [APB_AW-1:0] ADDR_ACCEL_RATE  = 4'h4;
    localparam logic [APB_AW-1:0] ADDR_REVERSE_DIR = 4'h8;

    // Event codes
    localparam logic [MODE_W-1:0] EV_POLL   = 2'd0;
    localparam logic [MODE_W-1:0] EV_RAMP   = 2'd1;
    localparam logic [MODE_W-1:0] EV_TARGET = 2'd2;
    localparam logic [MODE_W-1:0] EV_UNUSED = 2'd3;

    localparam int FINEST_MODE_DEF = 4;
    localparam logic [MSTEP_W-1:0] MODE_IDLE = 3'd7;

    // Serial arithmetic
    localparam int PROD_W = 56;
    localparam int QUOT_W = 28;
    localparam int CNT_W  = 6;
    localparam logic [QUOT_W-1:0] US_Q8 = 28'd256000000;
    localparam logic [SPEED_W-1:0] US_PER_S = 24'd1000000;

    localparam logic [TIME_W-1:0] MIN_PERIOD_RST = 32'd1000000;
    localparam logic [MAXSPD_W-1:0] MAX_SPEED_RST = 23'd256;
    localparam logic [ACCEL_W-1:0] ACCEL_RST = 24'd256;

    // Driver pin pattern {ms3,ms2,ms1} for a microstep mode
    function automatic logic [PINS_W-1:0] pins_of(input logic [MSTEP_W-1:0] m);
        logic [PINS_W-1:0] p;
        begin
            unique case (m)
                3'd0:    p = 3'd0;
                3'd1:    p = 3'd1;
                3'd2:    p = 3'd2;
                3'd3:    p = 3'd4;
                3'd4:    p = 3'd7;
                default: p = 3'd0;
            endcase
            return p;
        end
    endfunction

endpackage

/* sv/stpr_ifs.sv */
// Valid/ready channel interfaces for the event input and the result output.
// Depends on stpr_pkg for field widths.
interface stpr_in_if;
    logic                                valid;
    logic                                ready;
    logic [stpr_pkg::MODE_W-1:0]         mode;
    logic [stpr_pkg::TIME_W-1:0]         time_us;
    logic signed [stpr_pkg::SPEED_W-1:0] target_speed;

    modport source (output valid, mode, time_us, target_speed, input ready);
    modport sink   (input valid, mode, time_us, target_speed, output ready);
endinterface

interface stpr_out_if;
    logic                                valid;
    logic                                ready;
    logic                                step_pulse;
    logic                                direction;
    logic [stpr_pkg::PINS_W-1:0]         microstep_pins;
    logic signed [stpr_pkg::SPEED_W-1:0] current_speed;

    modport source (output valid, step_pulse, direction, microstep_pins, current_speed,
                    input ready);
    modport sink   (input valid, step_pulse, direction, microstep_pins, current_speed,
                    output ready);
endinterface

/* sv/stepper_ramp_microstep_pulser.sv */
// Stepper ramp generator and microstep pulser, top level.
// Depends on stpr_pkg and the channel interfaces in stpr_ifs.sv.
//
// Usage:
//   in_ch carries one event word: a timing poll, a ramp update or a new target
//   speed. Each gives one result word on out_ch (none if a max_speed write
//   comes meanwhile): step pulse, direction, microstep pins and present speed.
//   The APB port holds max_speed (0x0), accel_rate (0x4) and reverse_dir (0x8).
// Timing (one event in work at a time, one bit per cycle):
//   A poll, a target or an unused event passes the dispatch and emit states;
//   in_ch is ready again once its result is written. A ramp update off
//   target adds a serial multiply, a divide by one million and, at nonzero
//   speed, the step period divide and the mode search. A max_speed write
//   runs the minimum period divide (for a nonzero value) and the mode
//   search; in_ch is not ready meanwhile.
// Reset: rst_n clears all but the payload registers asynchronously to the
//   register defaults.
// Stall: a finished result sits in the output register; the next event is
//   taken while it waits, and its own result holds until the register frees.
module stepper_ramp_microstep_pulser #(
    parameter int FINEST_MODE = stpr_pkg::FINEST_MODE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    stpr_in_if.sink                       in_ch,
    stpr_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stpr_pkg::APB_AW-1:0]   paddr,
    input  logic [stpr_pkg::APB_DW-1:0]   pwdata,
    output logic [stpr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int SW = stpr_pkg::SPEED_W;
    localparam int TW = stpr_pkg::TIME_W;
    localparam int MW = stpr_pkg::MSTEP_W;
    localparam int PW = stpr_pkg::PROD_W;
    localparam int QW = stpr_pkg::QUOT_W;
    localparam int CW = stpr_pkg::CNT_W;
    localparam logic [MW-1:0] FINEST = MW'(FINEST_MODE);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_STEP = 3'd4;
    localparam logic [2:0] S_PER  = 3'd5;
    localparam logic [2:0] S_MODE = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    localparam logic [1:0] OP_DELTA  = 2'd0;
    localparam logic [1:0] OP_PERIOD = 2'd1;
    localparam logic [1:0] OP_MINP   = 2'd2;

    function automatic logic signed [SW-1:0] clamp_speed(
        input logic signed [SW-1:0] s,
        input logic [stpr_pkg::MAXSPD_W-1:0] lim
    );
        logic signed [SW:0] sx;
        logic signed [SW:0] lx;
        logic signed [SW-1:0] r;
        begin
            sx = {s[SW-1], s};
            lx = $signed({2'b00, lim});
            if (sx > lx)
                r = SW'(lx);
            else if (sx < -lx)
                r = SW'(-lx);
            else
                r = s;
            return r;
        end
    endfunction

    // Control state
    logic [2:0]  state_reg, state_next;
    logic [1:0]  op_reg, op_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic        from_cfg_reg, from_cfg_next;
    logic [MW-1:0] k_reg, k_next;
    logic [MW-1:0] macc_reg, macc_next;

    // Configuration
    logic [stpr_pkg::MAXSPD_W-1:0] max_speed_reg, max_speed_next;
    logic [stpr_pkg::ACCEL_W-1:0]  accel_reg, accel_next;
    logic        reverse_reg, reverse_next;

    // Motion state
    logic signed [SW-1:0] desired_reg, desired_next;
    logic signed [SW-1:0] ramp_reg, ramp_next;
    logic [TW-1:0] last_step_reg, last_step_next;
    logic [TW-1:0] last_upd_reg, last_upd_next;
    logic          started_reg, started_next;
    logic [TW-1:0] full_reg, full_next;
    logic [TW-1:0] min_reg, min_next;
    logic [TW-1:0] pos_reg, pos_next;
    logic [MW-1:0] wanted_reg, wanted_next;
    logic [MW-1:0] active_reg, active_next;

    // Latched event and serial datapath
    logic [stpr_pkg::MODE_W-1:0] ev_reg, ev_next;
    logic [TW-1:0]        t_reg, t_next;
    logic signed [SW-1:0] tgt_reg, tgt_next;
    logic [TW-1:0]        dt_reg, dt_next;
    logic [stpr_pkg::ACCEL_W-1:0] mbits_reg, mbits_next;
    logic [PW-1:0]        qd_reg, qd_next;
    logic [SW-1:0]        rem_reg, rem_next;
    logic [SW-1:0]        dvs_reg, dvs_next;
    logic                 pulse_reg, pulse_next;

    // Output register
    logic                 ovalid_reg, ovalid_next;
    logic                 opulse_reg, opulse_next;
    logic                 odir_reg, odir_next;
    logic [stpr_pkg::PINS_W-1:0] opins_reg, opins_next;
    logic signed [SW-1:0] ospeed_reg, ospeed_next;

    logic in_fire;
    logic cfg_wr;

    // Combinational helpers
    logic [SW:0]   div_sh;
    logic          div_ge;
    logic [MW-1:0] tz_v, want_tz, tz_c, nm;
    logic [TW-1:0] interval, elapsed;
    logic [24:0]   delta_sat;
    logic signed [SW+2:0] cur_x, want_x, dlt_x, n_x;
    logic [SW-1:0] mag;
    logic [TW+3:0] min_sh;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign cfg_wr      = psel && penable && pwrite;
    assign pready      = 1'b1;

    always_comb
    begin
        unique case (paddr)
            stpr_pkg::ADDR_MAX_SPEED:   prdata = {9'd0, max_speed_reg};
            stpr_pkg::ADDR_ACCEL_RATE:  prdata = {8'd0, accel_reg};
            stpr_pkg::ADDR_REVERSE_DIR: prdata = {31'd0, reverse_reg};
            default:                    prdata = '0;
        endcase
    end

    assign out_ch.valid          = ovalid_reg;
    assign out_ch.step_pulse     = opulse_reg;
    assign out_ch.direction      = odir_reg;
    assign out_ch.microstep_pins = opins_reg;
    assign out_ch.current_speed  = ospeed_reg;

    // One restoring-divide bit
    assign div_sh = {rem_reg, qd_reg[PW-1]};
    assign div_ge = (div_sh >= {1'b0, dvs_reg});

    // Poll: pick the coarsest mode the position allows, no coarser than the wanted one
    always_comb
    begin
        tz_v = FINEST;
        for (int i = FINEST_MODE - 1; i >= 0; i--)
        begin
            if (pos_reg[i])
                tz_v = MW'(i);
        end
        want_tz  = FINEST - wanted_reg;
        tz_c     = (tz_v < want_tz) ? tz_v : want_tz;
        nm       = FINEST - tz_c;
        interval = full_reg >> nm;
        elapsed  = t_reg - last_step_reg;
    end

    // Ramp step with saturated delta; no overshoot past the target
    always_comb
    begin
        delta_sat = (|qd_reg[PW-1:25]) ? '1 : qd_reg[24:0];
        cur_x  = (SW+3)'(ramp_reg);
        want_x = (SW+3)'(desired_reg);
        dlt_x  = $signed({2'b00, delta_sat});
        if (cur_x > want_x)
        begin
            n_x = cur_x - dlt_x;
            if (n_x < want_x)
                n_x = want_x;
        end
        else
        begin
            n_x = cur_x + dlt_x;
            if (n_x > want_x)
                n_x = want_x;
        end
        mag    = ramp_reg[SW-1] ? SW'(-ramp_reg) : ramp_reg;
        min_sh = {4'd0, min_reg} << k_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        from_cfg_next  = from_cfg_reg;
        k_next         = k_reg;
        macc_next      = macc_reg;
        max_speed_next = max_speed_reg;
        accel_next     = accel_reg;
        reverse_next   = reverse_reg;
        desired_next   = desired_reg;
        ramp_next      = ramp_reg;
        last_step_next = last_step_reg;
        last_upd_next  = last_upd_reg;
        started_next   = started_reg;
        full_next      = full_reg;
        min_next       = min_reg;
        pos_next       = pos_reg;
        wanted_next    = wanted_reg;
        active_next    = active_reg;
        ev_next        = ev_reg;
        t_next         = t_reg;
        tgt_next       = tgt_reg;
        dt_next        = dt_reg;
        mbits_next     = mbits_reg;
        qd_next        = qd_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        pulse_next     = pulse_reg;
        ovalid_next    = ovalid_reg;
        opulse_next    = opulse_reg;
        odir_next      = odir_reg;
        opins_next     = opins_reg;
        ospeed_next    = ospeed_reg;

        // Drop the result once taken
        if (ovalid_reg && out_ch.ready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    ev_next       = in_ch.mode;
                    t_next        = in_ch.time_us;
                    tgt_next      = in_ch.target_speed;
                    from_cfg_next = 1'b0;
                    state_next    = S_DISP;
                end
            end
            S_DISP:
            begin
                pulse_next = 1'b0;
                state_next = S_EMIT;
                priority if (ev_reg == stpr_pkg::EV_POLL)
                begin
                    if (!started_reg || wanted_reg > FINEST)
                    begin
                        last_step_next = t_reg;
                        started_next   = 1'b1;
                    end
                    else if (elapsed > interval)
                    begin
                        active_next    = nm;
                        last_step_next = last_step_reg + interval;
                        pos_next       = pos_reg + (TW'(1) << tz_c);
                        pulse_next     = 1'b1;
                    end
                end
                else if (ev_reg == stpr_pkg::EV_RAMP)
                begin
                    last_upd_next = t_reg;
                    if (ramp_reg != desired_reg)
                    begin
                        dt_next    = t_reg - last_upd_reg;
                        mbits_next = accel_reg;
                        qd_next    = '0;
                        cnt_next   = CW'(stpr_pkg::ACCEL_W);
                        state_next = S_MUL;
                    end
                end
                else if (ev_reg == stpr_pkg::EV_TARGET)
                begin
                    desired_next = clamp_speed(tgt_reg, max_speed_reg);
                end
                else
                begin
                    pulse_next = 1'b0;
                end
            end
            S_MUL:
            begin
                // Shift-add, multiplier bits MSB first
                qd_next    = {qd_reg[PW-2:0], 1'b0} +
                             (mbits_reg[stpr_pkg::ACCEL_W-1] ? PW'(dt_reg) : '0);
                mbits_next = {mbits_reg[stpr_pkg::ACCEL_W-2:0], 1'b0};
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    cnt_next   = CW'(PW);
                    rem_next   = '0;
                    dvs_next   = stpr_pkg::US_PER_S;
                    op_next    = OP_DELTA;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = div_ge ? SW'(div_sh - {1'b0, dvs_reg}) : div_sh[SW-1:0];
                qd_next  = {qd_reg[PW-2:0], div_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    k_next    = MW'(1);
                    macc_next = '0;
                    unique case (op_reg)
                        OP_DELTA:
                        begin
                            state_next = S_STEP;
                        end
                        OP_PERIOD:
                        begin
                            full_next  = TW'(qd_next[QW-1:0]);
                            state_next = S_MODE;
                        end
                        default:
                        begin
                            min_next   = TW'(qd_next[QW-1:0]);
                            state_next = S_MODE;
                        end
                    endcase
                end
            end
            S_STEP:
            begin
                ramp_next  = n_x[SW-1:0];
                state_next = S_PER;
            end
            S_PER:
            begin
                if (ramp_reg == '0)
                begin
                    full_next   = '1;
                    wanted_next = stpr_pkg::MODE_IDLE;
                    state_next  = S_EMIT;
                end
                else
                begin
                    qd_next    = {stpr_pkg::US_Q8, {(PW-QW){1'b0}}};
                    rem_next   = '0;
                    dvs_next   = mag;
                    cnt_next   = CW'(QW);
                    op_next    = OP_PERIOD;
                    state_next = S_DIV;
                end
            end
            S_MODE:
            begin
                // floor(log2(full/min)), capped at the finest mode, by one trial compare per cycle
                priority if (ramp_reg == '0)
                begin
                    wanted_next = stpr_pkg::MODE_IDLE;
                    state_next  = from_cfg_reg ? S_IDLE : S_EMIT;
                end
                else if (min_reg == '0)
                begin
                    wanted_next = FINEST;
                    state_next  = from_cfg_reg ? S_IDLE : S_EMIT;
                end
                else if (k_reg <= FINEST && {4'd0, full_reg} >= min_sh)
                begin
                    macc_next = k_reg;
                    k_next    = k_reg + 1'b1;
                end
                else
                begin
                    wanted_next = macc_reg;
                    state_next  = from_cfg_reg ? S_IDLE : S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!ovalid_reg || out_ch.ready)
                begin
                    ovalid_next = 1'b1;
                    opulse_next = pulse_reg;
                    odir_next   = ((ramp_reg > 0) ? 1'b1 : 1'b0) ^ reverse_reg;
                    opins_next  = stpr_pkg::pins_of(active_reg);
                    ospeed_next = ramp_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr)
        begin
            unique case (paddr)
                stpr_pkg::ADDR_MAX_SPEED:
                begin
                    max_speed_next = pwdata[stpr_pkg::MAXSPD_W-1:0];
                    desired_next   = clamp_speed(desired_reg,
                                                 pwdata[stpr_pkg::MAXSPD_W-1:0]);
                    from_cfg_next  = 1'b1;
                    k_next         = MW'(1);
                    macc_next      = '0;
                    if (pwdata[stpr_pkg::MAXSPD_W-1:0] == '0)
                    begin
                        min_next   = '1;
                        state_next = S_MODE;
                    end
                    else
                    begin
                        qd_next    = {stpr_pkg::US_Q8, {(PW-QW){1'b0}}};
                        rem_next   = '0;
                        dvs_next   = {1'b0, pwdata[stpr_pkg::MAXSPD_W-1:0]};
                        cnt_next   = CW'(QW);
                        op_next    = OP_MINP;
                        state_next = S_DIV;
                    end
                end
                stpr_pkg::ADDR_ACCEL_RATE:
                begin
                    accel_next = pwdata[stpr_pkg::ACCEL_W-1:0];
                end
                stpr_pkg::ADDR_REVERSE_DIR:
                begin
                    reverse_next = pwdata[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_DELTA;
            cnt_reg       <= '0;
            from_cfg_reg  <= 1'b0;
            k_reg         <= '0;
            macc_reg      <= '0;
            max_speed_reg <= stpr_pkg::MAX_SPEED_RST;
            accel_reg     <= stpr_pkg::ACCEL_RST;
            reverse_reg   <= 1'b0;
            desired_reg   <= '0;
            ramp_reg      <= '0;
            last_step_reg <= '0;
            last_upd_reg  <= '0;
            started_reg   <= 1'b0;
            full_reg      <= '0;
            min_reg       <= stpr_pkg::MIN_PERIOD_RST;
            pos_reg       <= '0;
            wanted_reg    <= stpr_pkg::MODE_IDLE;
            active_reg    <= MW'(1);
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            from_cfg_reg  <= from_cfg_next;
            k_reg         <= k_next;
            macc_reg      <= macc_next;
            max_speed_reg <= max_speed_next;
            accel_reg     <= accel_next;
            reverse_reg   <= reverse_next;
            desired_reg   <= desired_next;
            ramp_reg      <= ramp_next;
            last_step_reg <= last_step_next;
            last_upd_reg  <= last_upd_next;
            started_reg   <= started_next;
            full_reg      <= full_next;
            min_reg       <= min_next;
            pos_reg       <= pos_next;
            wanted_reg    <= wanted_next;
            active_reg    <= active_next;
            ovalid_reg    <= ovalid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        ev_reg     <= ev_next;
        t_reg      <= t_next;
        tgt_reg    <= tgt_next;
        dt_reg     <= dt_next;
        mbits_reg  <= mbits_next;
        qd_reg     <= qd_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        pulse_reg  <= pulse_next;
        opulse_reg <= opulse_next;
        odir_reg   <= odir_next;
        opins_reg  <= opins_next;
        ospeed_reg <= ospeed_next;
    end

`ifndef SYNTHESIS
    a_fire_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !cfg_wr |=> state_reg == S_DISP)
        else $error("accepted word did not reach dispatch");

    a_wanted_range: assert property (@(posedge clk) disable iff (!rst_n)
        wanted_reg <= FINEST || wanted_reg == stpr_pkg::MODE_IDLE)
        else $error("wanted mode out of range");

    a_active_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg <= FINEST)
        else $error("active mode out of range");

    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside emit");
`endif

endmodule
